### hw/rtl/ios_pkg.sv
`default_nettype none
package ios_pkg;

  // field widths of the request and response transactions
  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 6;
  localparam int MCOUNT_W = 7;

  // default store depth
  localparam int CAPACITY_DEF = 64;

  // request opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD      = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_CONTAINS = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_READ     = 3'd4
  } ios_op_t;

endpackage
`default_nettype wire

### hw/rtl/ios_if.sv
`default_nettype none
// request channel
interface ios_req_if;
  logic                                  valid;
  logic                                  ready;
  logic        [ios_pkg::OPCODE_W-1:0]   opcode;
  logic signed [ios_pkg::VALUE_W-1:0]    value;
  logic        [ios_pkg::INDEX_W-1:0]    index;

  modport source (output valid, output opcode, output value, output index, input ready);
  modport sink   (input valid, input opcode, input value, input index, output ready);
endinterface

// response channel
interface ios_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  ok;
  logic                                  full_refused;
  logic        [ios_pkg::MCOUNT_W-1:0]   member_count;
  logic signed [ios_pkg::VALUE_W-1:0]    read_value;

  modport source (output valid, output ok, output full_refused, output member_count,
                  output read_value, input ready);
  modport sink   (input valid, input ok, input full_refused, input member_count,
                  input read_value, output ready);
endinterface
`default_nettype wire

### hw/rtl/ios_ram.sv
`default_nettype none
module ios_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/insertion_ordered_set_store.sv
// add / contains scan the members in order, reading then comparing each one, and stop
// at a match or after the last member; remove, on a match, moves each later member down
// one place (a read, then a write) and then drops the count; read fetches the indexed
// member from the ram; clear, unused opcodes and a read past the members go straight to
// the result; no new request is taken until the result is registered in the output
// register; reset clears the member count and handshake state; the member ram is not cleared
`default_nettype none
module insertion_ordered_set_store #(
  parameter int CAPACITY = ios_pkg::CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ios_req_if.sink    in_req,
  ios_rsp_if.source  out_rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > ios_pkg::INDEX_W) ? CW : ios_pkg::INDEX_W;
  localparam int VW = ios_pkg::VALUE_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_CMP  = 7'b0000100,
    S_SHRD = 7'b0001000,
    S_SHWR = 7'b0010000,
    S_RDW  = 7'b0100000,
    S_RESP = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  ios_pkg::ios_op_t  op_r, op_nxt;
  logic [VW-1:0]     val_r, val_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              res_ok_r, res_ok_nxt;
  logic              res_full_r, res_full_nxt;
  logic [VW-1:0]     res_rd_r, res_rd_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_full_r;
  logic [ios_pkg::MCOUNT_W-1:0] out_count_r;
  logic [VW-1:0]     out_rd_r;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [VW-1:0]     ram_wdata, ram_rdata;

  logic              in_fire, out_load, shift_more;
  logic [XW-1:0]     idx_ext, cnt_ext;
  logic [CW:0]       ptr_inc;
  logic [CW+ios_pkg::MCOUNT_W-1:0] mcount_ext;

  // member storage
  ios_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;
  assign out_load     = (state_r == S_RESP) && (!out_valid_r || out_rsp.ready);
  assign idx_ext      = XW'(in_req.index);
  assign cnt_ext      = XW'(count_r);
  assign ptr_inc      = {1'b0, ptr_r} + 1'b1;
  assign shift_more   = (ptr_inc < {1'b0, count_r});
  assign mcount_ext   = {{ios_pkg::MCOUNT_W{1'b0}}, count_r};

  // sequencer: scan, shift and read through the member ram
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    val_nxt      = val_r;
    ptr_nxt      = ptr_r;
    count_nxt    = count_r;
    res_ok_nxt   = res_ok_r;
    res_full_nxt = res_full_r;
    res_rd_nxt   = res_rd_r;
    ram_we       = 1'b0;
    ram_waddr    = ptr_r[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = ptr_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt       = ios_pkg::ios_op_t'(in_req.opcode);
          val_nxt      = in_req.value;
          ptr_nxt      = '0;
          res_ok_nxt   = 1'b0;
          res_full_nxt = 1'b0;
          res_rd_nxt   = '0;
          case (in_req.opcode)
            ios_pkg::OP_ADD, ios_pkg::OP_REMOVE, ios_pkg::OP_CONTAINS: begin
              state_nxt = S_SCAN;
            end
            ios_pkg::OP_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_RESP;
            end
            ios_pkg::OP_READ: begin
              if (idx_ext < cnt_ext) begin
                ram_re    = 1'b1;
                ram_raddr = idx_ext[AW-1:0];
                state_nxt = S_RDW;
              end else begin
                state_nxt = S_RESP;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ptr_r == count_r) begin
          // value absent
          state_nxt = S_RESP;
          if (op_r == ios_pkg::OP_ADD) begin
            if (count_r >= CW'(CAPACITY)) begin
              res_full_nxt = 1'b1;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = count_r[AW-1:0];
              ram_wdata  = val_r;
              count_nxt  = count_r + 1'b1;
              res_ok_nxt = 1'b1;
            end
          end
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (ram_rdata == val_r) begin
          case (op_r)
            ios_pkg::OP_REMOVE: begin
              state_nxt = S_SHRD;
            end
            ios_pkg::OP_CONTAINS: begin
              res_ok_nxt = 1'b1;
              state_nxt  = S_RESP;
            end
            default: begin
              // duplicate add
              state_nxt = S_RESP;
            end
          endcase
        end else begin
          ptr_nxt   = ptr_inc[CW-1:0];
          state_nxt = S_SCAN;
        end
      end
      S_SHRD: begin
        if (shift_more) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_inc[AW-1:0];
          state_nxt = S_SHWR;
        end else begin
          count_nxt  = count_r - 1'b1;
          res_ok_nxt = 1'b1;
          state_nxt  = S_RESP;
        end
      end
      S_SHWR: begin
        // move the later member down one place
        ram_we    = 1'b1;
        ram_waddr = ptr_r[AW-1:0];
        ram_wdata = ram_rdata;
        ptr_nxt   = ptr_inc[CW-1:0];
        state_nxt = S_SHRD;
      end
      S_RDW: begin
        res_rd_nxt = ram_rdata;
        res_ok_nxt = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    ptr_r      <= ptr_nxt;
    res_ok_r   <= res_ok_nxt;
    res_full_r <= res_full_nxt;
    res_rd_r   <= res_rd_nxt;
    if (out_load) begin
      out_ok_r    <= res_ok_r;
      out_full_r  <= res_full_r;
      out_count_r <= mcount_ext[ios_pkg::MCOUNT_W-1:0];
      out_rd_r    <= res_rd_r;
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.ok           = out_ok_r;
  assign out_rsp.full_refused = out_full_r;
  assign out_rsp.member_count = out_count_r;
  assign out_rsp.read_value   = out_rd_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("member count above capacity");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SCAN || state_r == S_SHWR))
    else $error("member ram written outside append or shift");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHRD && !shift_more) |=> (count_r == $past(count_r) - 1'b1))
    else $error("remove did not drop the count by one");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req.opcode == ios_pkg::OP_CLEAR) |=> (count_r == '0))
    else $error("clear left members behind");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp.ready) |=> (out_valid_r && $stable(out_count_r)))
    else $error("pending result changed before it was taken");

endmodule
`default_nettype wire
